// ===== src/qsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// qsfd_pkg
// Shared types and constants of the quality score frame decoder.
// ----------------------------------------------------------------------------
package qsfd_pkg;

  // code byte classes
  localparam logic [7:0] RUN_FLOOR    = 8'd201;
  localparam logic [7:0] TRIPLE_FLOOR = 8'd137;
  localparam logic [7:0] PAIR_FLOOR   = 8'd73;
  localparam logic [7:0] LIT_OFFSET   = 8'd32;
  localparam logic [7:0] HDR_MAX      = 8'd128;
  localparam logic [7:0] TRIPLE_BIAS  = 8'd3;
  localparam logic [7:0] PAIR_BIAS    = 8'd7;

  // configuration
  localparam int          LINE_LEN_W     = 16;
  localparam logic [15:0] LINE_LEN_RESET = 16'd100;
  localparam int          APB_ADDR_W     = 3;
  localparam int          APB_DATA_W     = 32;
  localparam logic        REG_LINE_LENGTH = 1'b0;

  // parameter defaults
  localparam int LINE_POS_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_RUN,
    OP_TRIPLE,
    OP_PAIR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] base;
    logic [5:0] digits;
    logic [5:0] count;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

endpackage

// ===== src/qsfd_if.sv =====
// ----------------------------------------------------------------------------
// qsfd channel interfaces
// Valid/ready channels for code bytes, decoder commands and symbols.
// ----------------------------------------------------------------------------
interface qsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface qsfd_cmd_if;
  logic          valid;
  logic          ready;
  qsfd_pkg::cmd_t cmd;

  modport source (output valid, output cmd, input ready);
  modport sink (input valid, input cmd, output ready);
endinterface

interface qsfd_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       line_end;
  logic       last;

  modport source (output valid, output symbol, output line_end, output last, input ready);
  modport sink (input valid, input symbol, input line_end, input last, output ready);
endinterface

// ===== src/quality_score_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// quality_score_frame_decoder
// Decodes framed, compressed quality score bytes into quality symbols.
// ----------------------------------------------------------------------------
// code: valid/ready channel of compressed bytes, one byte per transfer.
//   A zero byte ends a frame; the first byte of a frame is its header.
// sym: valid/ready channel of decoded symbols with line_end and last flags;
//   last marks the final symbol produced by one code byte.
// APB port: register line_length at byte address 0, reset value 100.
// Path: a code byte is written into the command queue when it transfers,
//   the generator loads it from the queue into its command registers, and
//   its first symbol is then registered in the output register.
// Throughput: the symbol generator emits one symbol per cycle while sym
//   takes them; each command also passes its load step first. A header of
//   128 or less only uses the load step; other bytes without symbols skip it.
// The command queue lets bytes that give no symbol pass while the
//   generator works. A stalled sym channel holds the output register,
//   then the generator, then the queue, and finally code.ready drops.
// Reset clears frame tracking, the queue, the line position and the
//   output register, and returns line_length to 100.
// ----------------------------------------------------------------------------
module quality_score_frame_decoder #(
  parameter int LINE_POS_BITS = qsfd_pkg::LINE_POS_BITS_DEF,
  parameter int QUEUE_DEPTH   = qsfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  qsfd_byte_if.sink                         code,
  qsfd_sym_if.source                        sym,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qsfd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [qsfd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [qsfd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [qsfd_pkg::LINE_LEN_W-1:0] line_length;
  logic                            reg_hit;

  qsfd_cmd_if cmd_q_in ();
  qsfd_cmd_if cmd_q_out ();

  assign pready  = 1'b1;
  assign reg_hit = paddr[qsfd_pkg::APB_ADDR_W-1] == qsfd_pkg::REG_LINE_LENGTH;
  assign prdata  = reg_hit ? qsfd_pkg::APB_DATA_W'(line_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= qsfd_pkg::LINE_LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      line_length <= pwdata[qsfd_pkg::LINE_LEN_W-1:0];
    end
  end

  qsfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .code    (code),
    .cmd_out (cmd_q_in.source)
  );

  qsfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk (clk),
    .rst (rst),
    .wr  (cmd_q_in.sink),
    .rd  (cmd_q_out.source)
  );

  qsfd_back #(
    .LINE_POS_BITS (LINE_POS_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .line_length (line_length),
    .cmd_in      (cmd_q_out.sink),
    .sym         (sym)
  );

endmodule

// ===== src/qsfd_front.sv =====
// ----------------------------------------------------------------------------
// qsfd_front
// Frame tracking and byte classification into decoder commands.
// ----------------------------------------------------------------------------
module qsfd_front (
  input  logic         clk,
  input  logic         rst,
  qsfd_byte_if.sink    code,
  qsfd_cmd_if.source   cmd_out
);

  logic       frame_open;
  logic       skip_frame;
  logic [7:0] ref_q;
  logic       accept;
  logic [7:0] b;
  logic       hdr_skip;
  qsfd_pkg::cmd_t cmd_next;
  logic       push;

  assign b        = code.code_byte;
  assign accept   = code.valid && code.ready;
  assign hdr_skip = b > qsfd_pkg::HDR_MAX;
  assign code.ready = cmd_out.ready;

  always_comb begin
    cmd_next = '{op: qsfd_pkg::OP_CLEAR, base: ref_q, digits: 6'd0, count: 6'd0};
    push     = 1'b0;
    if (!frame_open) begin
      push = (b != 8'd0) && !hdr_skip;
    end else if (b != 8'd0 && !skip_frame) begin
      if (b >= qsfd_pkg::RUN_FLOOR) begin
        cmd_next.op    = qsfd_pkg::OP_RUN;
        cmd_next.count = 6'(b - qsfd_pkg::RUN_FLOOR);
        push           = b != qsfd_pkg::RUN_FLOOR;
      end else if (b >= qsfd_pkg::TRIPLE_FLOOR) begin
        cmd_next.op     = qsfd_pkg::OP_TRIPLE;
        cmd_next.base   = ref_q - qsfd_pkg::TRIPLE_BIAS;
        cmd_next.digits = 6'(b - qsfd_pkg::TRIPLE_FLOOR);
        cmd_next.count  = 6'd3;
        push            = 1'b1;
      end else if (b >= qsfd_pkg::PAIR_FLOOR) begin
        cmd_next.op     = qsfd_pkg::OP_PAIR;
        cmd_next.base   = ref_q - qsfd_pkg::PAIR_BIAS;
        cmd_next.digits = 6'(b - qsfd_pkg::PAIR_FLOOR);
        cmd_next.count  = 6'd2;
        push            = 1'b1;
      end else begin
        cmd_next.op    = qsfd_pkg::OP_RUN;
        cmd_next.base  = b + qsfd_pkg::LIT_OFFSET;
        cmd_next.count = 6'd1;
        push           = 1'b1;
      end
    end
  end

  assign cmd_out.valid = code.valid && push;
  assign cmd_out.cmd   = cmd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      skip_frame <= 1'b0;
      ref_q      <= 8'd0;
    end else if (accept) begin
      if (!frame_open) begin
        if (b != 8'd0) begin
          frame_open <= 1'b1;
          skip_frame <= hdr_skip;
          ref_q      <= b;
        end
      end else if (b == 8'd0) begin
        frame_open <= 1'b0;
        skip_frame <= 1'b0;
      end
    end
  end

endmodule

// ===== src/qsfd_fifo.sv =====
// ----------------------------------------------------------------------------
// qsfd_fifo
// Short command queue between the classifier and the symbol generator.
// ----------------------------------------------------------------------------
module qsfd_fifo #(
  parameter int DEPTH = qsfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  qsfd_cmd_if.sink   wr,
  qsfd_cmd_if.source rd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qsfd_pkg::cmd_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign wr.ready = fill != CNT_W'(DEPTH);
  assign rd.valid = fill != '0;
  assign rd.cmd   = mem[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== src/qsfd_back.sv =====
// ----------------------------------------------------------------------------
// qsfd_back
// Symbol generator: expands commands into symbols, tracks line position.
// ----------------------------------------------------------------------------
module qsfd_back #(
  parameter int LINE_POS_BITS = qsfd_pkg::LINE_POS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [qsfd_pkg::LINE_LEN_W-1:0] line_length,
  qsfd_cmd_if.sink                        cmd_in,
  qsfd_sym_if.source                      sym
);

  localparam int CMP_W = (LINE_POS_BITS > qsfd_pkg::LINE_LEN_W) ?
                         LINE_POS_BITS : qsfd_pkg::LINE_LEN_W;

  qsfd_pkg::back_state_t state;
  qsfd_pkg::back_state_t state_next;
  qsfd_pkg::op_t         cur_op;
  logic [7:0]            cur_base;
  logic [5:0]            cur_digits;
  logic [5:0]            remaining;
  logic [LINE_POS_BITS-1:0] line_pos;
  logic [LINE_POS_BITS-1:0] pos_inc;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      len_ext;
  logic                  brk;
  logic [7:0]            digit;
  logic [7:0]            sym_value;
  logic                  ovalid;
  logic [7:0]            symbol_q;
  logic                  line_end_q;
  logic                  last_q;
  logic                  slot_free;
  logic                  emit;
  logic                  take;

  assign slot_free = !ovalid || sym.ready;
  assign pos_inc   = line_pos + 1'b1;
  assign pos_ext   = CMP_W'(pos_inc);
  assign len_ext   = CMP_W'(line_length);
  assign brk       = (line_length != '0) && (pos_ext == len_ext);
  assign sym_value = cur_base + digit;

  always_comb begin
    case (cur_op)
      qsfd_pkg::OP_TRIPLE: digit = {6'd0, cur_digits[5:4]};
      qsfd_pkg::OP_PAIR:   digit = {5'd0, cur_digits[5:3]};
      default:             digit = 8'd0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      qsfd_pkg::B_IDLE: begin
        if (cmd_in.valid && cmd_in.cmd.op != qsfd_pkg::OP_CLEAR) begin
          state_next = qsfd_pkg::B_EMIT;
        end
      end
      qsfd_pkg::B_EMIT: begin
        if (slot_free && remaining == 6'd1) begin
          state_next = qsfd_pkg::B_IDLE;
        end
      end
      default: state_next = qsfd_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_in.ready = 1'b0;
    emit         = 1'b0;
    case (state)
      qsfd_pkg::B_IDLE: cmd_in.ready = 1'b1;
      qsfd_pkg::B_EMIT: emit = slot_free;
      default: begin
        cmd_in.ready = 1'b0;
        emit         = 1'b0;
      end
    endcase
  end

  assign take = cmd_in.valid && cmd_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= qsfd_pkg::B_IDLE;
      line_pos <= '0;
      ovalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (take && cmd_in.cmd.op == qsfd_pkg::OP_CLEAR) begin
        line_pos <= '0;
      end else if (emit) begin
        line_pos <= brk ? '0 : pos_inc;
      end
      if (emit) begin
        ovalid <= 1'b1;
      end else if (sym.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_op     <= cmd_in.cmd.op;
      cur_base   <= cmd_in.cmd.base;
      cur_digits <= cmd_in.cmd.digits;
      remaining  <= cmd_in.cmd.count;
    end else if (emit) begin
      remaining <= remaining - 1'b1;
      case (cur_op)
        qsfd_pkg::OP_TRIPLE: cur_digits <= {cur_digits[3:0], 2'b00};
        qsfd_pkg::OP_PAIR:   cur_digits <= {cur_digits[2:0], 3'b000};
        default:             cur_digits <= cur_digits;
      endcase
    end
    if (emit) begin
      symbol_q   <= sym_value;
      line_end_q <= brk;
      last_q     <= remaining == 6'd1;
    end
  end

  assign sym.valid    = ovalid;
  assign sym.symbol   = symbol_q;
  assign sym.line_end = line_end_q;
  assign sym.last     = last_q;

`ifndef SYNTH
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == qsfd_pkg::B_EMIT |-> remaining != 6'd0)
    else $error("emit state with no symbols left");

  a_break_clears: assert property (@(posedge clk) disable iff (rst)
    emit && brk |=> line_pos == '0)
    else $error("line position not cleared after line break");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit && remaining == 6'd1 |=> state == qsfd_pkg::B_IDLE && sym.last)
    else $error("final symbol did not end the command");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quality_score_frame_decoder. Code bytes are sent
// as directed frames, then as random frames under several line lengths, with
// bursty input and a stalling symbol sink. A scoreboard class predicts every
// symbol transfer and compares it field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [7:0] RUN_BASE    = 8'd201;
  localparam logic [7:0] TRIPLE_BASE = 8'd137;
  localparam logic [7:0] PAIR_BASE   = 8'd73;
  localparam logic [7:0] LIT_SHIFT   = 8'd32;
  localparam logic [7:0] HEADER_MAX  = 8'd128;
  localparam logic [7:0] TRIPLE_OFS  = 8'd3;
  localparam logic [7:0] PAIR_OFS    = 8'd7;

  localparam logic [qsfd_pkg::APB_ADDR_W-1:0] ADDR_LINE_LENGTH = 3'd0;

  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0] symbol;
    logic       line_end;
    logic       last;
  } sym_exp_t;

  class symbol_scoreboard;
    logic [15:0] line_len;
    logic        hdr_seen;
    logic        drop_frame;
    logic [7:0]  base_q;
    logic [15:0] col;
    sym_exp_t    expected[$];
    int          errors;

    function new();
      line_len   = 16'd100;
      hdr_seen   = 1'b0;
      drop_frame = 1'b0;
      base_q     = 8'd0;
      col        = 16'd0;
      errors     = 0;
    endfunction

    function void set_line_length(logic [15:0] len);
      line_len = len;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void push_symbol(logic [7:0] s);
      logic [15:0] nxt;
      logic        brk;
      nxt = col + 16'd1;
      brk = 1'b0;
      if (line_len != 16'd0 && nxt == line_len) begin
        brk = 1'b1;
        nxt = 16'd0;
      end
      col = nxt;
      expected.push_back('{symbol: s, line_end: brk, last: 1'b0});
    endfunction

    function void note_byte(logic [7:0] b);
      int          before_cnt;
      logic [7:0]  v;
      sym_exp_t    tail;
      before_cnt = expected.size();
      if (!hdr_seen) begin
        if (b != 8'd0) begin
          hdr_seen   = 1'b1;
          drop_frame = (b > HEADER_MAX);
          base_q     = b;
          col        = 16'd0;
        end
        return;
      end
      if (b == 8'd0) begin
        hdr_seen   = 1'b0;
        drop_frame = 1'b0;
        return;
      end
      if (drop_frame)
        return;
      if (b >= RUN_BASE) begin
        for (int i = 0; i < int'(b - RUN_BASE); i++)
          push_symbol(base_q);
      end else if (b >= TRIPLE_BASE) begin
        v = b - TRIPLE_BASE;
        push_symbol(8'({6'd0, v[5:4]} + base_q - TRIPLE_OFS));
        push_symbol(8'({6'd0, v[3:2]} + base_q - TRIPLE_OFS));
        push_symbol(8'({6'd0, v[1:0]} + base_q - TRIPLE_OFS));
      end else if (b >= PAIR_BASE) begin
        v = b - PAIR_BASE;
        push_symbol(8'({5'd0, v[5:3]} + base_q - PAIR_OFS));
        push_symbol(8'({5'd0, v[2:0]} + base_q - PAIR_OFS));
      end else begin
        push_symbol(8'(b + LIT_SHIFT));
      end
      if (expected.size() > before_cnt) begin
        tail = expected.pop_back();
        tail.last = 1'b1;
        expected.push_back(tail);
      end
    endfunction

    function void check_symbol(logic [7:0] s, logic le, logic lst);
      sym_exp_t e;
      if (expected.size() == 0) begin
        $error("unexpected symbol transfer: symbol %0d line_end %0b last %0b", s, le, lst);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (s !== e.symbol) begin
        $error("symbol mismatch: expected %0d, actual %0d", e.symbol, s);
        errors++;
      end
      if (le !== e.line_end) begin
        $error("line_end mismatch: expected %0b, actual %0b", e.line_end, le);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last mismatch: expected %0b, actual %0b", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [qsfd_pkg::APB_ADDR_W-1:0] paddr;
  logic [qsfd_pkg::APB_DATA_W-1:0] pwdata;
  logic [qsfd_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  logic tx_idle;
  logic rx_stall;
  logic hold_req;
  int   burst_left;

  symbol_scoreboard sb = new();

  qsfd_byte_if code_if ();
  qsfd_sym_if  sym_if ();

  quality_score_frame_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .code    (code_if.sink),
    .sym     (sym_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // symbol sink: stall pattern, plus one long hold-off on request
  initial begin
    logic [15:0] pattern;
    int          idx;
    int          hold_cnt;
    pattern = '1;
    idx = 0;
    hold_cnt = 0;
    sym_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && sym_if.valid && sym_if.ready)
        sb.check_symbol(sym_if.symbol, sym_if.line_end, sym_if.last);
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        sym_if.ready <= 1'b0;
      end else begin
        if (idx == 0)
          pattern = rx_stall ? 16'($urandom | $urandom) : '1;
        sym_if.ready <= pattern[idx];
        idx = (idx + 1) % 16;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (tx_idle && burst_left == 0) begin
      code_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0)
      burst_left--;
    code_if.valid <= 1'b1;
    code_if.code_byte <= b;
    do @(posedge clk); while (!code_if.ready);
    sb.note_byte(b);
  endtask

  task automatic wait_idle();
    code_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_length(input logic [15:0] len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_LINE_LENGTH;
    pwdata  <= {16'd0, len};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_line_length(len);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] rand_code();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(1, 72));
      3, 4, 5: return 8'($urandom_range(73, 136));
      6, 7, 8: return 8'($urandom_range(137, 200));
      default: return 8'($urandom_range(201, 255));
    endcase
  endfunction

  // mostly well-formed frames, some skipped frames, noise and missing ends
  task automatic run_frames(input int n_items);
    int sent;
    int r;
    int body;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        body = $urandom_range(0, 10);
        if (r == 1)
          send_byte(8'($urandom_range(129, 255)));
        else
          send_byte(8'($urandom_range(1, 128)));
        repeat (body) send_byte(rand_code());
        sent += body + 1;
        if ($urandom_range(0, 15) != 0) begin
          send_byte(8'd0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [7:0]  directed[$];
    logic [15:0] lens[PHASES];
    directed = '{8'd0,
                 8'd128, 8'd1, 8'd72, 8'd73, 8'd136, 8'd137, 8'd200,
                 8'd201, 8'd202, 8'd255, 8'd0,
                 8'd1, 8'd73, 8'd136, 8'd137, 8'd200, 8'd255, 8'd0,
                 8'd129, 8'd5, 8'd255, 8'd0,
                 8'd255, 8'd1, 8'd0};
    rst <= 1'b1;
    code_if.valid <= 1'b0;
    code_if.code_byte <= 8'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_req <= 1'b0;
    tx_idle = 1'b1;
    rx_stall = 1'b1;
    burst_left = 0;
    lens[0] = 16'd1;
    lens[1] = 16'd65535;
    lens[2] = 16'd0;
    lens[3] = 16'($urandom_range(2, 40));
    lens[4] = 16'($urandom_range(41, 300));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_line_length(lens[p]);
      tx_idle  = (p != 1);
      rx_stall = (p != 1);
      burst_left = 0;
      if (p == 3) begin
        tx_idle = 1'b0;
        hold_req <= 1'b1;
      end
      run_frames(PHASE_ITEMS);
    end

    code_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/qsfd_pkg.sv
src/qsfd_if.sv
src/qsfd_front.sv
src/qsfd_fifo.sv
src/qsfd_back.sv
src/quality_score_frame_decoder.sv
verif/tb_top.sv
